@@ hdl/highlife_torus_generation_step_assert.svh @@
// Assertion macros for the HighLife grid engine
`ifndef HIGHLIFE_TORUS_GENERATION_STEP_ASSERT_SVH
`define HIGHLIFE_TORUS_GENERATION_STEP_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define HLTG_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hltg assertion failed");

// next-cycle implication
`define HLTG_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hltg assertion failed");

`endif

@@ hdl/hltg_pkg.sv @@
// Shared constants and types for the HighLife grid engine
`default_nettype none

package hltg_pkg;

  localparam int MAX_SIDE = 64;
  localparam int IDX_W    = $clog2(MAX_SIDE);
  localparam int SIDE_W   = $clog2(MAX_SIDE + 1);
  localparam int CFG_W    = 7;
  localparam int POS_W    = 6;
  localparam int POP_W    = 13;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_STEP  = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef logic [MAX_SIDE-1:0] row_t;
  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [SIDE_W-1:0]   side_t;

  typedef struct packed {
    logic nxt;
    logic old;
  } cell_res_t;

endpackage

`default_nettype wire

@@ hdl/hltg_row_ram.sv @@
// Row-wide cell memory with per-row valid bits (invalid rows read as dead)
`default_nettype none

module hltg_row_ram
  import hltg_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  rd_en_i,
  input  idx_t rd_addr_i,
  output row_t rd_data_o,
  input  wire  wr_en_i,
  input  idx_t wr_addr_i,
  input  row_t wr_data_i
);

  row_t                mem_q [MAX_SIDE];
  row_t                rd_mem_q;
  logic [MAX_SIDE-1:0] vld_q;
  logic                rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_mem_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_mem_q : '0;

endmodule

`default_nettype wire

@@ hdl/hltg_rule_unit.sv @@
// Shared cell unit: toroidal neighbor count and B36/S23 rule for one column
`default_nettype none

module hltg_rule_unit
  import hltg_pkg::*;
(
  input  row_t      prev_i,
  input  row_t      cur_i,
  input  row_t      next_i,
  input  idx_t      col_i,
  input  side_t     side_i,
  output cell_res_t res_o
);

  side_t      side_m1;
  idx_t       last_col;
  idx_t       lf;
  idx_t       rt;
  logic [3:0] n;
  logic       old;

  assign side_m1  = side_i - side_t'(1);
  assign last_col = side_m1[IDX_W-1:0];
  assign lf       = (col_i == '0) ? last_col : col_i - idx_t'(1);
  assign rt       = (col_i == last_col) ? '0 : col_i + idx_t'(1);
  assign old      = cur_i[col_i];

  assign n = 4'(prev_i[lf]) + 4'(prev_i[col_i]) + 4'(prev_i[rt])
           + 4'(cur_i[lf])  + 4'(cur_i[rt])
           + 4'(next_i[lf]) + 4'(next_i[col_i]) + 4'(next_i[rt]);

  assign res_o.old = old;
  assign res_o.nxt = (n == 4'd3) || (n == 4'd2 && old) || (n == 4'd6 && !old);

endmodule

`default_nettype wire

@@ hdl/highlife_torus_generation_step.sv @@
// Top level: HighLife (B36/S23) toroidal grid with write, read and step requests
// Write/read: row/col are first reduced modulo the side by repeated subtraction (up to 63).
// Step: after the same modulo reduction, every row of the active side s is swept and written back.
// The sweep evaluates one cell per cycle through the shared rule unit.
// One request in flight; a new one is taken once the previous result is registered.
// Reset: async active low; all cells dead, population 0, side 64, no clearing pass.
`default_nettype none

module highlife_torus_generation_step
  import hltg_pkg::*;
(
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               cfg_we_i,
  input  wire [CFG_W-1:0]   cfg_wdata_i,
  input  wire               req_valid_i,
  output logic              req_ready_o,
  input  wire [1:0]         op_i,
  input  wire [POS_W-1:0]   row_i,
  input  wire [POS_W-1:0]   col_i,
  input  wire               cell_in_i,
  output logic              rsp_valid_o,
  input  wire               rsp_ready_i,
  output logic              cell_out_o,
  output logic [POP_W-1:0]  population_o
);

`include "highlife_torus_generation_step_assert.svh"

  typedef enum logic [3:0] {
    S_IDLE,
    S_MOD,
    S_CELL_RD,
    S_CELL_OP,
    S_ST_RD0,
    S_ST_RDL,
    S_ST_LAST,
    S_ST_NXT,
    S_ST_NXTW,
    S_ST_SWEEP,
    S_ST_WB,
    S_DONE
  } state_e;

  state_e           state_q;
  logic [CFG_W-1:0] grid_side_q;
  logic [POP_W-1:0] live_q;
  logic [1:0]       op_q;
  logic             cell_v_q;
  side_t            r_q;
  side_t            c_q;
  logic             cell_res_q;
  logic             rsp_valid_q;
  logic             cell_out_q;
  logic [POP_W-1:0] pop_q;

  row_t prev_q;
  row_t cur_q;
  row_t next_q;
  row_t row0_q;
  row_t newrow_q;

  side_t     side;
  side_t     side_m1;
  idx_t      r_idx;
  idx_t      c_idx;
  logic      rd_en;
  idx_t      rd_addr;
  row_t      rd_data;
  logic      wr_en;
  idx_t      wr_addr;
  row_t      wr_data;
  row_t      cell_row;
  cell_res_t res;
  logic      out_free;

  always_comb begin
    if (grid_side_q == '0) begin
      side = side_t'(1);
    end else if (32'(grid_side_q) > MAX_SIDE) begin
      side = side_t'(MAX_SIDE);
    end else begin
      side = side_t'(grid_side_q);
    end
  end

  assign side_m1  = side - side_t'(1);
  assign r_idx    = r_q[IDX_W-1:0];
  assign c_idx    = c_q[IDX_W-1:0];
  assign out_free = !rsp_valid_q || rsp_ready_i;

  always_comb begin
    cell_row        = rd_data;
    cell_row[c_idx] = cell_v_q;
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = r_idx;
    case (state_q)
      S_CELL_RD: begin
        rd_en = 1'b1;
      end
      S_ST_RD0: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      S_ST_RDL: begin
        rd_en   = 1'b1;
        rd_addr = side_m1[IDX_W-1:0];
      end
      S_ST_NXT: begin
        rd_en   = (r_q != side_m1);
        rd_addr = r_idx + idx_t'(1);
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = r_idx;
    wr_data = newrow_q;
    case (state_q)
      S_CELL_OP: begin
        wr_en   = (op_q == OP_WRITE);
        wr_data = cell_row;
      end
      S_ST_WB: begin
        wr_en = 1'b1;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  hltg_row_ram u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  hltg_rule_unit u_rule (
    .prev_i (prev_q),
    .cur_i  (cur_q),
    .next_i (next_q),
    .col_i  (c_idx),
    .side_i (side),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      grid_side_q <= CFG_W'(MAX_SIDE);
      live_q      <= '0;
      op_q        <= OP_WRITE;
      cell_v_q    <= 1'b0;
      r_q         <= '0;
      c_q         <= '0;
      cell_res_q  <= 1'b0;
      rsp_valid_q <= 1'b0;
      cell_out_q  <= 1'b0;
      pop_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        grid_side_q <= cfg_wdata_i;
      end
      if (rsp_valid_q && rsp_ready_i && state_q != S_DONE) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req_valid_i) begin
            op_q       <= op_i;
            cell_v_q   <= cell_in_i;
            r_q        <= side_t'(row_i);
            c_q        <= side_t'(col_i);
            cell_res_q <= 1'b0;
            state_q    <= S_MOD;
          end
        end
        S_MOD: begin
          if (r_q >= side) begin
            r_q <= r_q - side;
          end
          if (c_q >= side) begin
            c_q <= c_q - side;
          end
          if (r_q < side && c_q < side) begin
            case (op_q)
              OP_WRITE, OP_READ: state_q <= S_CELL_RD;
              OP_STEP:           state_q <= S_ST_RD0;
              default:           state_q <= S_DONE;
            endcase
          end
        end
        S_CELL_RD: begin
          state_q <= S_CELL_OP;
        end
        S_CELL_OP: begin
          if (op_q == OP_WRITE) begin
            live_q <= live_q + POP_W'(cell_v_q) - POP_W'(rd_data[c_idx]);
          end else begin
            cell_res_q <= rd_data[c_idx];
          end
          state_q <= S_DONE;
        end
        S_ST_RD0: begin
          r_q     <= '0;
          state_q <= S_ST_RDL;
        end
        S_ST_RDL: begin
          state_q <= S_ST_LAST;
        end
        S_ST_LAST: begin
          state_q <= S_ST_NXT;
        end
        S_ST_NXT: begin
          c_q     <= '0;
          state_q <= (r_q == side_m1) ? S_ST_SWEEP : S_ST_NXTW;
        end
        S_ST_NXTW: begin
          state_q <= S_ST_SWEEP;
        end
        S_ST_SWEEP: begin
          live_q <= live_q + POP_W'(res.nxt) - POP_W'(res.old);
          c_q    <= c_q + side_t'(1);
          if (c_q == side_m1) begin
            state_q <= S_ST_WB;
          end
        end
        S_ST_WB: begin
          if (r_q == side_m1) begin
            state_q <= S_DONE;
          end else begin
            r_q     <= r_q + side_t'(1);
            state_q <= S_ST_NXT;
          end
        end
        S_DONE: begin
          if (out_free) begin
            rsp_valid_q <= 1'b1;
            cell_out_q  <= cell_res_q;
            pop_q       <= live_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // row window and next-row buffer
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_ST_RDL: begin
        row0_q <= rd_data;
        cur_q  <= rd_data;
      end
      S_ST_LAST: begin
        prev_q <= rd_data;
      end
      S_ST_NXT: begin
        newrow_q <= cur_q;
        if (r_q == side_m1) begin
          next_q <= row0_q;
        end
      end
      S_ST_NXTW: begin
        next_q <= rd_data;
      end
      S_ST_SWEEP: begin
        newrow_q[c_idx] <= res.nxt;
      end
      S_ST_WB: begin
        prev_q <= cur_q;
        cur_q  <= next_q;
      end
      default: begin
        newrow_q <= newrow_q;
      end
    endcase
  end

  assign req_ready_o  = (state_q == S_IDLE);
  assign rsp_valid_o  = rsp_valid_q;
  assign cell_out_o   = cell_out_q;
  assign population_o = pop_q;

  `HLTG_ASSERT_NXT(a_busy_after_req, req_valid_i && req_ready_o, !req_ready_o)
  `HLTG_ASSERT_IMP(a_cell_in_range, state_q == S_CELL_RD, r_q < side && c_q < side)
  `HLTG_ASSERT_IMP(a_sweep_in_range, state_q == S_ST_SWEEP, c_q < side && r_q < side)
  `HLTG_ASSERT_IMP(a_pop_bound, 1'b1, 32'(live_q) <= MAX_SIDE * MAX_SIDE)

endmodule

`default_nettype wire
